/* hdl/isbi_pkg.sv */
// shared types and constants for the indexed block search/insert core
// no dependencies; imported by the core and its checker
`timescale 1ns / 1ps

package isbi_pkg;

    localparam int KEY_W     = 24;
    localparam int REG_W     = 18;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 6;
    localparam int CFG_IDX_W = 3;

    localparam int NUM_BLOCKS_DEF = 4;
    localparam int BLOCK_SIZE_DEF = 16;
    localparam int NUM_REGS       = 4;

    // group key reset value of block zero; block b resets to this plus b
    localparam int BLOCK_KEY_BASE = 10801;

    // key / 100 as (key * RECIP) >> RECIP_SHIFT, exact for 24-bit keys
    localparam int GROUP_DIV   = 100;
    localparam int RECIP_SHIFT = 31;
    localparam int RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + GROUP_DIV - 1) / GROUP_DIV);

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_BLOCK  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    localparam logic REQ_SEARCH = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef struct packed {
        logic             req_type;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    position;
    } rsp_t;

endpackage

/* hdl/indexed_block_search_insert_core.sv */
// indexed block search/insert core: top level
// depends on isbi_pkg; isbi_checker is bound to it from its own file
`timescale 1ns / 1ps

// channel    direction  handshake                      payload
// request    in         start && !busy                 req (req_type, key)
// result     out        done, one-cycle strobe         rsp (status, position)
// config     in         cfg_valid && cfg_ready         cfg_index, cfg_data
//
// a request that finds no block for its group, and every insert, ends in
// S_ACT; a search goes on to S_SCAN and reads the filled entries of its block
// (at most BLOCK_SIZE) one entry per cycle through the single read port of the
// entry memory, stopping at the first slot that holds the key.
// reset clears the fill counts and restores the block group keys; the entry
// memory needs no clearing since only filled slots are ever compared.
// the receiver cannot stall: done marks the result for exactly one cycle and
// a new request may be accepted in that same cycle.

module indexed_block_search_insert_core
    import isbi_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF,
    parameter int BLOCK_SIZE = BLOCK_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // request side
    input  logic                 start,
    output logic                 busy,
    input  req_t                 req,
    // result side
    output logic                 done,
    output rsp_t                 rsp,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_data
);

    localparam int DEPTH = NUM_BLOCKS * BLOCK_SIZE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int FW    = $clog2(BLOCK_SIZE + 1);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_MATCH = 3'd2;
    localparam logic [2:0] S_ACT   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;

    logic [2:0]        state_reg, state_next;

    // captured request
    logic              type_reg;
    logic [KEY_W-1:0]  key_reg;

    // group of the key, block lookup result
    logic [KEY_W+RECIP_W-1:0] grp_prod;
    logic [REG_W-1:0]  grp_reg;
    logic              hit_comb;
    logic [BW-1:0]     blk_comb;
    logic              hit_reg;
    logic [BW-1:0]     blk_reg;

    // block group keys and fill counts
    logic [REG_W-1:0]  bkey [NUM_BLOCKS];
    logic [FW-1:0]     fill_reg [NUM_BLOCKS];
    logic              cfg_we;

    // scan control
    logic [AW-1:0]     base_reg;
    logic [FW-1:0]     idx_reg;
    logic [FW-1:0]     lim_reg;
    logic              pend_reg;
    logic [AW-1:0]     paddr_reg;

    // entry memory
    logic [KEY_W-1:0]  mem [DEPTH];
    logic [KEY_W-1:0]  rdata_reg;
    logic [AW-1:0]     mem_addr;
    logic              mem_we;

    // datapath helpers
    logic [AW-1:0]     act_base;
    logic [FW-1:0]     act_fill;
    logic [AW-1:0]     act_addr;
    logic [AW-1:0]     scan_addr;
    logic              scan_issue;
    logic              scan_hit;

    // result register
    logic              done_reg, done_next;
    rsp_t              rsp_reg, rsp_next;

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign rsp       = rsp_reg;
    // writes must only arrive while idle (the core does not enforce this); the channel is always open
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid;

    // ---------------------------------------------------------------
    // block group keys: the first NUM_REGS blocks are programmable,
    // any further block keeps its reset key
    // ---------------------------------------------------------------
    for (genvar b = 0; b < NUM_BLOCKS; b++) begin : g_bkey
        if (b < NUM_REGS) begin : g_prog
            logic [REG_W-1:0] bkey_reg;
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    bkey_reg <= REG_W'(BLOCK_KEY_BASE + b);
                end
                else if (cfg_we && cfg_index == CFG_IDX_W'(b))
                begin
                    bkey_reg <= cfg_data;
                end
            end
            assign bkey[b] = bkey_reg;
        end
        else begin : g_fixed
            assign bkey[b] = REG_W'(BLOCK_KEY_BASE + b);
        end
    end

    // group = key / 100 by reciprocal multiply, registered in S_DIV
    assign grp_prod = {{RECIP_W{1'b0}}, key_reg} * {{KEY_W{1'b0}}, RECIP};

    // lowest numbered block whose group key matches
    always_comb
    begin
        hit_comb = 1'b0;
        blk_comb = '0;
        for (int b = NUM_BLOCKS - 1; b >= 0; b--)
        begin
            if (bkey[b] == grp_reg)
            begin
                hit_comb = 1'b1;
                blk_comb = BW'(b);
            end
        end
    end

    // block base, fill and addresses
    assign act_base   = AW'(32'(blk_reg) * BLOCK_SIZE);
    assign act_fill   = fill_reg[blk_reg];
    assign act_addr   = act_base + AW'(act_fill);
    assign scan_addr  = base_reg + AW'(idx_reg);
    assign scan_issue = (idx_reg < lim_reg);
    assign scan_hit   = pend_reg && (rdata_reg == key_reg);

    assign mem_addr = (state_reg == S_ACT) ? act_addr : scan_addr;
    assign mem_we   = (state_reg == S_ACT) && hit_reg && (type_reg == REQ_INSERT)
                      && (act_fill != FW'(BLOCK_SIZE));

    // entry memory: one port, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= key_reg;
        end
        rdata_reg <= mem[mem_addr];
    end

    // fill counts
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NUM_BLOCKS; b++)
            begin
                fill_reg[b] <= '0;
            end
        end
        else if (mem_we)
        begin
            fill_reg[blk_reg] <= act_fill + FW'(1);
        end
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                state_next = S_MATCH;
            end
            S_MATCH:
            begin
                state_next = S_ACT;
            end
            S_ACT:
            begin
                if (!hit_reg)
                begin
                    state_next        = S_IDLE;
                    done_next         = 1'b1;
                    rsp_next.status   = ST_NO_BLOCK;
                    rsp_next.position = '0;
                end
                else if (type_reg == REQ_INSERT)
                begin
                    state_next = S_IDLE;
                    done_next  = 1'b1;
                    if (act_fill == FW'(BLOCK_SIZE))
                    begin
                        rsp_next.status   = ST_FULL;
                        rsp_next.position = '0;
                    end
                    else
                    begin
                        rsp_next.status   = ST_OK;
                        rsp_next.position = POS_W'(32'(act_addr));
                    end
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // compare the previous read, issue the next one
                if (scan_hit)
                begin
                    state_next        = S_IDLE;
                    done_next         = 1'b1;
                    rsp_next.status   = ST_OK;
                    rsp_next.position = POS_W'(32'(paddr_reg));
                end
                else if (!scan_issue)
                begin
                    state_next        = S_IDLE;
                    done_next         = 1'b1;
                    rsp_next.status   = ST_NOT_FOUND;
                    rsp_next.position = '0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (state_reg == S_SCAN)
            begin
                pend_reg <= scan_issue && !scan_hit;
            end
            else
            begin
                pend_reg <= 1'b0;
            end
        end
    end

    // payload and scan registers, no reset needed
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (state_reg == S_IDLE && start)
        begin
            type_reg <= req.req_type;
            key_reg  <= req.key;
        end
        if (state_reg == S_DIV)
        begin
            grp_reg <= grp_prod[RECIP_SHIFT +: REG_W];
        end
        if (state_reg == S_MATCH)
        begin
            hit_reg <= hit_comb;
            blk_reg <= blk_comb;
        end
        if (state_reg == S_ACT)
        begin
            base_reg <= act_base;
            lim_reg  <= act_fill;
            idx_reg  <= '0;
        end
        else if (state_reg == S_SCAN && scan_issue)
        begin
            idx_reg   <= idx_reg + FW'(1);
            paddr_reg <= scan_addr;
        end
    end

endmodule

/* hdl/isbi_checker.sv */
// port-level checker for the indexed block search/insert core
// depends on isbi_pkg; bound to indexed_block_search_insert_core below
`timescale 1ns / 1ps

module isbi_checker
    import isbi_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  logic done,
    input  rsp_t rsp
);

    // an accepted request keeps the core busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in flight");

    // a result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    // the core is free again when its result shows
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("busy while result is shown");

    // failed requests report slot zero
    a_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.position == '0))
        else $error("nonzero position on failed request");

endmodule

bind indexed_block_search_insert_core isbi_checker u_isbi_checker
(
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .rsp   (rsp)
);

/* bench/tb_indexed_block_search_insert_core.sv */
// self-checking bench for indexed_block_search_insert_core
// depends on isbi_pkg and the core; predicts every result from its own copy of the table
`timescale 1ns / 1ps

module tb_indexed_block_search_insert_core;
    import isbi_pkg::*;

    localparam int NUM_BLOCKS    = NUM_BLOCKS_DEF;
    localparam int BLOCK_SIZE    = BLOCK_SIZE_DEF;
    localparam int TABLE_DEPTH   = NUM_BLOCKS * BLOCK_SIZE;
    localparam int KEY_MAX       = (1 << KEY_W) - 1;
    localparam int GROUP_MAX     = KEY_MAX / GROUP_DIV;
    localparam int IDX_MAX       = (1 << CFG_IDX_W) - 1;
    // first key of the group that block zero serves after reset
    localparam int FIRST_KEY     = BLOCK_KEY_BASE * GROUP_DIV;
    localparam int IDLE_PCT      = 17;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 100;
    localparam int REPORT_MAX    = 10;

    localparam logic [CFG_IDX_W-1:0] IDX_BLOCK_KEY_0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_BLOCK_KEY_1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_BLOCK_KEY_2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_BLOCK_KEY_3 = 3'd3;

    // every input starts at a known value
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    req_t                 req       = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [REG_W-1:0]     cfg_data  = '0;
    logic                 busy;
    logic                 done;
    logic                 cfg_ready;
    rsp_t                 rsp;

    // bench copy of the table: group keys, entries and fill counts
    logic [REG_W-1:0] tbl_group_key [NUM_BLOCKS];
    logic [KEY_W-1:0] tbl_entry [TABLE_DEPTH];
    int               tbl_fill [NUM_BLOCKS];

    req_t             pending_q[$];    // requests waiting to be driven
    rsp_t             expected_q[$];   // predicted results, oldest first
    logic [KEY_W-1:0] fresh_keys[$];   // keys queued for insert in the current phase

    int   issued_count   = 0;
    int   accepted_count = 0;
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    logic steady_run     = 1'b0;      // no sender idling while set

    indexed_block_search_insert_core #(
        .NUM_BLOCKS (NUM_BLOCKS),
        .BLOCK_SIZE (BLOCK_SIZE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // apply one request to the bench table and return the result it must produce
    function automatic rsp_t serve_request(req_t r);
        int unsigned grp;
        int          blk;
        int          base;
        rsp_t        res;
        grp          = r.key / GROUP_DIV;
        blk          = -1;
        res.status   = ST_NO_BLOCK;
        res.position = '0;
        // lowest numbered block wins when group keys repeat
        for (int b = NUM_BLOCKS - 1; b >= 0; b--)
        begin
            if (tbl_group_key[b] == grp)
                blk = b;
        end
        if (blk >= 0)
        begin
            base = blk * BLOCK_SIZE;
            if (r.req_type == REQ_INSERT)
            begin
                if (tbl_fill[blk] >= BLOCK_SIZE)
                    res.status = ST_FULL;
                else
                begin
                    tbl_entry[base + tbl_fill[blk]] = r.key;
                    res.status   = ST_OK;
                    res.position = POS_W'(base + tbl_fill[blk]);
                    tbl_fill[blk]++;
                end
            end
            else
            begin
                // walk down so the lowest matching slot is the one kept
                res.status = ST_NOT_FOUND;
                for (int i = tbl_fill[blk] - 1; i >= 0; i--)
                begin
                    if (tbl_entry[base + i] == r.key)
                    begin
                        res.status   = ST_OK;
                        res.position = POS_W'(base + i);
                    end
                end
            end
        end
        return res;
    endfunction

    // random key inside a group; the top group is only partly populated
    function automatic logic [KEY_W-1:0] group_member(int unsigned grp);
        int unsigned k;
        k = grp * GROUP_DIV + $urandom_range(GROUP_DIV - 1);
        if (k > KEY_MAX)
            k = KEY_MAX - $urandom_range(KEY_MAX % GROUP_DIV);
        return k[KEY_W-1:0];
    endfunction

    // key likely to hit something: a stored entry, a fresh insert, or a group member
    function automatic logic [KEY_W-1:0] likely_key(int blk);
        int n;
        n = $urandom_range(99);
        if (n < 45 && tbl_fill[blk] != 0)
            return tbl_entry[blk * BLOCK_SIZE + $urandom_range(tbl_fill[blk] - 1)];
        if (n < 75 && fresh_keys.size() != 0)
            return fresh_keys[$urandom_range(fresh_keys.size() - 1)];
        return group_member(tbl_group_key[blk]);
    endfunction

    task automatic queue_request(logic kind, logic [KEY_W-1:0] k);
        pending_q.push_back('{req_type: kind, key: k});
        issued_count++;
    endtask

    // config write; only called while the core is idle
    task automatic write_block_key(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        // indexes past the register list are dropped by the core
        if (idx < NUM_REGS && idx < NUM_BLOCKS)
            tbl_group_key[idx] = value;
    endtask

    // wait until every queued request is accepted and answered, then let the core settle
    task automatic wait_table_idle();
        while (accepted_count != issued_count || expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one phase of random requests, mostly aimed at the configured groups
    task automatic queue_random_phase(int items);
        int               blk;
        int               n;
        logic [KEY_W-1:0] k;
        fresh_keys.delete();
        repeat (items)
        begin
            blk = $urandom_range(NUM_BLOCKS - 1);
            n   = $urandom_range(99);
            if (n < 15)
            begin
                // new key appended to a configured group
                k = group_member(tbl_group_key[blk]);
                fresh_keys.push_back(k);
                queue_request(REQ_INSERT, k);
            end
            else if (n < 20)
                queue_request(REQ_INSERT, likely_key(blk));   // mostly duplicates
            else if (n < 88)
                queue_request(REQ_SEARCH, likely_key(blk));
            else
                queue_request(logic'($urandom_range(1)), KEY_W'($urandom));  // noise
        end
    endtask

    // request driver: start is held until the core takes the request
    always @(posedge clk)
    begin : request_driver
        if (rst_n)
        begin
            if (start && !busy)
            begin
                expected_q.push_back(serve_request(req));
                accepted_count++;
            end
            // the channel is free when idle or when the request just went in
            if (!start || !busy)
            begin
                if (pending_q.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PCT))
                begin
                    start <= 1'b1;
                    req   <= pending_q.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // result checker: done marks one result, compared against the oldest prediction
    always @(posedge clk)
    begin : result_checker
        rsp_t want;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("cycle %0d: result with none pending, status %0d position %0d",
                             cycle_count, rsp.status, rsp.position);
            end
            else
            begin
                want = expected_q.pop_front();
                if (rsp.status !== want.status || rsp.position !== want.position)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("cycle %0d: status exp %0d got %0d, position exp %0d got %0d",
                                 cycle_count, want.status, rsp.status,
                                 want.position, rsp.position);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        logic [REG_W-1:0] key_value;

        // bench table matches the state after reset
        for (int b = 0; b < NUM_BLOCKS; b++)
        begin
            tbl_group_key[b] = REG_W'(BLOCK_KEY_BASE + b);
            tbl_fill[b]      = 0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset group keys, empty blocks
        queue_request(REQ_SEARCH, KEY_W'(FIRST_KEY));          // empty block, not found
        queue_request(REQ_SEARCH, '0);                         // smallest key, no block
        queue_request(REQ_INSERT, KEY_W'(KEY_MAX));            // largest key, no block
        queue_request(REQ_INSERT, KEY_W'(FIRST_KEY));
        queue_request(REQ_INSERT, KEY_W'(FIRST_KEY + 99));
        queue_request(REQ_SEARCH, KEY_W'(FIRST_KEY + 99));
        queue_request(REQ_SEARCH, KEY_W'(FIRST_KEY + 50));     // right group, absent key
        queue_request(REQ_INSERT, KEY_W'(FIRST_KEY));          // duplicate appended
        queue_request(REQ_SEARCH, KEY_W'(FIRST_KEY));          // lowest copy reported
        queue_request(REQ_INSERT, KEY_W'(FIRST_KEY + 300));    // last block
        queue_request(REQ_INSERT, KEY_W'(FIRST_KEY + 150));
        queue_request(REQ_SEARCH, KEY_W'(FIRST_KEY + 150));
        queue_request(REQ_SEARCH, KEY_W'(FIRST_KEY + 250));    // block still empty
        wait_table_idle();

        // extreme group keys, two blocks sharing a group, writes to unused indexes
        write_block_key(IDX_BLOCK_KEY_0, '0);
        write_block_key(IDX_BLOCK_KEY_1, REG_W'(GROUP_MAX));
        write_block_key(IDX_BLOCK_KEY_2, REG_W'(GROUP_MAX));
        write_block_key(IDX_BLOCK_KEY_3, REG_W'(131071));
        write_block_key(CFG_IDX_W'(NUM_REGS), REG_W'(GROUP_MAX));
        write_block_key(CFG_IDX_W'(IDX_MAX), '0);

        queue_request(REQ_INSERT, '0);
        queue_request(REQ_INSERT, KEY_W'(99));
        queue_request(REQ_SEARCH, KEY_W'(99));
        queue_request(REQ_SEARCH, '0);
        queue_request(REQ_INSERT, KEY_W'(KEY_MAX));            // shared group, block one serves
        queue_request(REQ_SEARCH, KEY_W'(KEY_MAX));
        queue_request(REQ_SEARCH, KEY_W'(KEY_MAX - 15));       // absent in the top group
        queue_request(REQ_SEARCH, KEY_W'(FIRST_KEY));          // its group is gone
        queue_request(REQ_INSERT, KEY_W'(131071 * GROUP_DIV + 99));

        // random phases; each boundary holds the sender until all results are back
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_table_idle();
            steady_run <= (p == 1);
            for (int r = 0; r < NUM_REGS; r++)
            begin
                if (p == 1 || p == 4)
                begin
                    // move each block back to the group of what it holds
                    if (tbl_fill[r] != 0)
                        key_value = REG_W'(tbl_entry[r * BLOCK_SIZE] / GROUP_DIV);
                    else
                        key_value = REG_W'(BLOCK_KEY_BASE + r);
                end
                else if (p == 3 && r < 2)
                    key_value = (r == 0) ? REG_W'(GROUP_MAX) : '0;
                else if (p == 2 && r == NUM_REGS - 1)
                    key_value = tbl_group_key[0];                 // repeated group key
                else
                    key_value = REG_W'($urandom_range(GROUP_MAX));
                write_block_key(CFG_IDX_W'(r), key_value);
            end
            write_block_key(CFG_IDX_W'($urandom_range(IDX_MAX, NUM_REGS)),
                            REG_W'($urandom_range(GROUP_MAX)));
            queue_random_phase(PHASE_ITEMS);
        end

        wait_table_idle();
        if (mismatch_count == 0 && expected_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
